@@ hdl/pfgr_pkg.sv @@
// Shared types, constants and helper functions of the glyph rasterizer.
package pfgr_pkg;

  localparam int unsigned FONT_BYTES       = 4096;
  localparam int unsigned ADDR_W           = $clog2(FONT_BYTES);
  localparam int unsigned MAX_GLYPH_WIDTH  = 64;
  localparam int unsigned MAX_GLYPH_HEIGHT = 64;
  localparam int unsigned XY_W             = 11;
  localparam int unsigned COLOR_W          = 16;
  localparam int unsigned PIX_W            = 64;
  localparam int unsigned RW_W             = 7;
  localparam int unsigned BYTE_W           = 8;

  localparam logic [ADDR_W-1:0] HEIGHT_ADDR = ADDR_W'(1);
  localparam logic [ADDR_W-1:0] FIRST_ADDR  = ADDR_W'(2);
  localparam logic [ADDR_W-1:0] COUNT_ADDR  = ADDR_W'(3);
  localparam logic [ADDR_W-1:0] WIDTH_BASE  = ADDR_W'(4);

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_DRAW = 1'b1;

  localparam logic REG_FOREGROUND = 1'b0;
  localparam logic REG_BACKGROUND = 1'b1;

  localparam logic [COLOR_W-1:0] FOREGROUND_RESET = 16'hFFFF;
  localparam logic [COLOR_W-1:0] BACKGROUND_RESET = 16'h0000;

  typedef struct packed {
    logic             action;
    logic [11:0]      font_addr;
    logic [7:0]       font_byte;
    logic [7:0]       char_code;
    logic             new_string;
    logic [XY_W-1:0]  start_x;
    logic [XY_W-1:0]  start_y;
  } in_req_t;

  typedef struct packed {
    logic [PIX_W-1:0]   row_pixels;
    logic [RW_W-1:0]    row_width;
    logic [XY_W-1:0]    pixel_x;
    logic [XY_W-1:0]    pixel_y;
    logic [COLOR_W-1:0] set_color;
    logic [COLOR_W-1:0] clear_color;
    logic               last_row;
    logic               error;
  } out_rsp_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixels;
    logic [RW_W-1:0]  width;
    logic [XY_W-1:0]  x;
    logic [XY_W-1:0]  y;
    logic             last;
    logic             error;
  } row_t;

  function automatic logic [5:0] row_bytes(input logic [7:0] w);
    logic [8:0] sum;
    sum = {1'b0, w} + 9'd7;
    return (w == 8'd0) ? 6'd1 : sum[8:3];
  endfunction

  function automatic logic [PIX_W-1:0] reverse_bits(input logic [PIX_W-1:0] v);
    logic [PIX_W-1:0] r;
    for (int i = 0; i < PIX_W; i++) begin
      r[i] = v[PIX_W-1-i];
    end
    return r;
  endfunction

endpackage

@@ hdl/proportional_font_glyph_rasterizer.sv @@
// Top level of the glyph rasterizer: font store, sequencer, colors and result register.
//
//   channel  direction  handshake                 payload
//   in       request    in_valid_i / in_ready_o   in_req_i  (pfgr_pkg::in_req_t)
//   out      result     out_valid_o / out_ready_i out_rsp_o (pfgr_pkg::out_rsp_t)
//   cfg      write      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// A font load request is written to the font store when it is accepted. A draw request holds
// the input while the sequencer reads the font header, walks the widths of the glyphs before
// it in the font to find its start, and reads each row's bytes before that row is emitted;
// the single read port of the font store reads one byte per cycle. A code out of range or a
// glyph too wide ends the draw in one error result; a draw in an aborted string gives none.
// Reset clears the pen, the abort flag, the sequencer and the result valid flag; the font
// store keeps no reset. A stalled result holds the sequencer at the row it has built.
module proportional_font_glyph_rasterizer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  pfgr_pkg::in_req_t                 in_req_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output pfgr_pkg::out_rsp_t                out_rsp_o,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [pfgr_pkg::COLOR_W-1:0]      cfg_data_i
);

  logic                               ram_we;
  logic [pfgr_pkg::ADDR_W-1:0]        ram_waddr;
  logic [pfgr_pkg::BYTE_W-1:0]        ram_wdata;
  logic [pfgr_pkg::ADDR_W-1:0]        ram_raddr;
  logic [pfgr_pkg::BYTE_W-1:0]        ram_rdata;
  logic                               res_valid;
  logic                               res_ready;
  pfgr_pkg::row_t                     res;
  logic [pfgr_pkg::COLOR_W-1:0]       fg_q;
  logic [pfgr_pkg::COLOR_W-1:0]       bg_q;
  logic                               out_valid_q;
  pfgr_pkg::out_rsp_t                 out_rsp_q;

  pfgr_ram #(
    .WIDTH (pfgr_pkg::BYTE_W),
    .DEPTH (pfgr_pkg::FONT_BYTES)
  ) u_font_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pfgr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= pfgr_pkg::FOREGROUND_RESET;
      bg_q <= pfgr_pkg::BACKGROUND_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pfgr_pkg::REG_FOREGROUND: fg_q <= cfg_data_i;
        pfgr_pkg::REG_BACKGROUND: bg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_rsp_q.row_pixels  <= res.pixels;
      out_rsp_q.row_width   <= res.width;
      out_rsp_q.pixel_x     <= res.x;
      out_rsp_q.pixel_y     <= res.y;
      out_rsp_q.set_color   <= fg_q;
      out_rsp_q.clear_color <= bg_q;
      out_rsp_q.last_row    <= res.last;
      out_rsp_q.error       <= res.error;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.error |-> out_rsp_o.last_row && (out_rsp_o.row_width == '0))
    else $error("error result must be a single empty row");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.row_width <= 7'(pfgr_pkg::MAX_GLYPH_WIDTH))
    else $error("row width above the glyph limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_rsp_o.row_pixels >> out_rsp_o.row_width) == '0))
    else $error("pixel bits set beyond the row width");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> in_ready_o && !res_valid)
    else $error("font store written while a draw is in progress");

endmodule

@@ hdl/pfgr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module pfgr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hdl/pfgr_ctrl.sv @@
// Sequencer that walks the font store and builds one glyph row at a time.
module pfgr_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pfgr_pkg::in_req_t             in_req_i,
  output logic                          ram_we_o,
  output logic [pfgr_pkg::ADDR_W-1:0]   ram_waddr_o,
  output logic [pfgr_pkg::BYTE_W-1:0]   ram_wdata_o,
  output logic [pfgr_pkg::ADDR_W-1:0]   ram_raddr_o,
  input  logic [pfgr_pkg::BYTE_W-1:0]   ram_rdata_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output pfgr_pkg::row_t                res_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD_H = 4'd1;
  localparam logic [3:0] S_RD_F = 4'd2;
  localparam logic [3:0] S_RD_C = 4'd3;
  localparam logic [3:0] S_RD_W = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_WALK = 4'd6;
  localparam logic [3:0] S_ROW  = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;
  localparam logic [3:0] S_ERR  = 4'd9;

  localparam int unsigned AW = pfgr_pkg::ADDR_W;
  localparam int unsigned XW = pfgr_pkg::XY_W;

  logic [3:0]                     state_q, state_d;
  logic [XW-1:0]                  pen_x_q, pen_x_d;
  logic [XW-1:0]                  pen_y_q, pen_y_d;
  logic                           aborted_q, aborted_d;
  logic [7:0]                     code_q, code_d;
  logic [7:0]                     height_q, height_d;
  logic [7:0]                     first_q, first_d;
  logic [7:0]                     count_q, count_d;
  logic [7:0]                     idx_q, idx_d;
  logic [7:0]                     walk_i_q, walk_i_d;
  logic                           acc_v_q, acc_v_d;
  logic [AW-1:0]                  start_q, start_d;
  logic [6:0]                     width_q, width_d;
  logic [3:0]                     bpr_q, bpr_d;
  logic [6:0]                     rows_q, rows_d;
  logic [6:0]                     row_q, row_d;
  logic [AW-1:0]                  addr_q, addr_d;
  logic [3:0]                     bi_q, bi_d;
  logic                           rv_q, rv_d;
  logic [2:0]                     rj_q, rj_d;
  logic [pfgr_pkg::PIX_W-1:0]     raw_q, raw_d;

  logic [13:0]                    walk_prod;
  logic [8:0]                     first_end;
  logic                           in_range;
  logic                           last_row;
  logic [6:0]                     row_next;
  logic [5:0]                     rb_rd;
  logic [5:0]                     rb_new;

  assign in_ready_o  = (state_q == S_IDLE);
  assign ram_we_o    = in_ready_o && in_valid_i && (in_req_i.action == pfgr_pkg::ACT_LOAD);
  assign ram_waddr_o = in_req_i.font_addr;
  assign ram_wdata_o = in_req_i.font_byte;

  assign rb_rd     = pfgr_pkg::row_bytes(ram_rdata_i);
  assign rb_new    = pfgr_pkg::row_bytes(ram_rdata_i);
  assign walk_prod = 14'(height_q) * 14'(rb_rd);
  assign first_end = {1'b0, first_q} + {1'b0, count_q};
  assign in_range  = (code_q >= first_q) && ({1'b0, code_q} < first_end);
  assign row_next  = row_q + 7'd1;
  assign last_row  = (row_next == rows_q);

  always_comb begin
    res_o        = '0;
    res_o.x      = pen_x_q;
    if (state_q == S_ERR) begin
      res_o.y     = pen_y_q;
      res_o.last  = 1'b1;
      res_o.error = 1'b1;
    end else begin
      res_o.pixels = pfgr_pkg::reverse_bits(raw_q) >> (7'd64 - width_q);
      res_o.width  = width_q;
      res_o.y      = pen_y_q + XW'(row_q);
      res_o.last   = last_row;
    end
  end

  assign res_valid_o = (state_q == S_EMIT) || (state_q == S_ERR);

  always_comb begin
    state_d     = state_q;
    pen_x_d     = pen_x_q;
    pen_y_d     = pen_y_q;
    aborted_d   = aborted_q;
    code_d      = code_q;
    height_d    = height_q;
    first_d     = first_q;
    count_d     = count_q;
    idx_d       = idx_q;
    walk_i_d    = walk_i_q;
    acc_v_d     = 1'b0;
    start_d     = start_q;
    width_d     = width_q;
    bpr_d       = bpr_q;
    rows_d      = rows_q;
    row_d       = row_q;
    addr_d      = addr_q;
    bi_d        = bi_q;
    rv_d        = 1'b0;
    rj_d        = rj_q;
    raw_d       = raw_q;
    ram_raddr_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && (in_req_i.action == pfgr_pkg::ACT_DRAW)) begin
          code_d = in_req_i.char_code;
          if (in_req_i.new_string) begin
            pen_x_d   = in_req_i.start_x;
            pen_y_d   = in_req_i.start_y;
            aborted_d = 1'b0;
            state_d   = S_RD_H;
          end else if (!aborted_q) begin
            state_d = S_RD_H;
          end
        end
      end
      S_RD_H: begin
        ram_raddr_o = pfgr_pkg::HEIGHT_ADDR;
        state_d     = S_RD_F;
      end
      S_RD_F: begin
        ram_raddr_o = pfgr_pkg::FIRST_ADDR;
        height_d    = ram_rdata_i;
        state_d     = S_RD_C;
      end
      S_RD_C: begin
        ram_raddr_o = pfgr_pkg::COUNT_ADDR;
        first_d     = ram_rdata_i;
        state_d     = S_RD_W;
      end
      S_RD_W: begin
        count_d     = ram_rdata_i;
        ram_raddr_o = pfgr_pkg::WIDTH_BASE + AW'(code_q - first_q);
        state_d     = S_CHK;
      end
      S_CHK: begin
        if (!in_range || (ram_rdata_i > 8'(pfgr_pkg::MAX_GLYPH_WIDTH))) begin
          state_d = S_ERR;
        end else begin
          width_d  = ram_rdata_i[6:0];
          bpr_d    = rb_new[3:0];
          idx_d    = code_q - first_q;
          start_d  = pfgr_pkg::WIDTH_BASE + AW'(count_q);
          walk_i_d = '0;
          rows_d   = (height_q > 8'(pfgr_pkg::MAX_GLYPH_HEIGHT)) ?
                     7'(pfgr_pkg::MAX_GLYPH_HEIGHT) : height_q[6:0];
          state_d  = S_WALK;
        end
      end
      S_WALK: begin
        if (walk_i_q != idx_q) begin
          ram_raddr_o = pfgr_pkg::WIDTH_BASE + AW'(walk_i_q);
          walk_i_d    = walk_i_q + 8'd1;
          acc_v_d     = 1'b1;
        end
        if (acc_v_q) begin
          start_d = start_q + walk_prod[AW-1:0];
        end
        if ((walk_i_q == idx_q) && !acc_v_q) begin
          if (rows_q == 7'd0) begin
            pen_x_d = pen_x_q + XW'(width_q);
            state_d = S_IDLE;
          end else begin
            addr_d  = start_q;
            row_d   = '0;
            bi_d    = '0;
            state_d = S_ROW;
          end
        end
      end
      S_ROW: begin
        if (bi_q != bpr_q) begin
          ram_raddr_o = addr_q;
          addr_d      = addr_q + AW'(1);
          bi_d        = bi_q + 4'd1;
          rv_d        = 1'b1;
          rj_d        = bi_q[2:0];
        end
        if (rv_q) begin
          raw_d[{rj_q, 3'b000} +: 8] = ram_rdata_i;
        end
        if ((bi_q == bpr_q) && !rv_q) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (res_ready_i) begin
          if (last_row) begin
            pen_x_d = pen_x_q + XW'(width_q);
            state_d = S_IDLE;
          end else begin
            row_d   = row_next;
            bi_d    = '0;
            state_d = S_ROW;
          end
        end
      end
      S_ERR: begin
        if (res_ready_i) begin
          aborted_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pen_x_q   <= '0;
      pen_y_q   <= '0;
      aborted_q <= 1'b0;
      acc_v_q   <= 1'b0;
      rv_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      pen_x_q   <= pen_x_d;
      pen_y_q   <= pen_y_d;
      aborted_q <= aborted_d;
      acc_v_q   <= acc_v_d;
      rv_q      <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q   <= code_d;
    height_q <= height_d;
    first_q  <= first_d;
    count_q  <= count_d;
    idx_q    <= idx_d;
    walk_i_q <= walk_i_d;
    start_q  <= start_d;
    width_q  <= width_d;
    bpr_q    <= bpr_d;
    rows_q   <= rows_d;
    row_q    <= row_d;
    addr_q   <= addr_d;
    bi_q     <= bi_d;
    rj_q     <= rj_d;
    raw_q    <= raw_d;
  end

endmodule

@@ test/proportional_font_glyph_rasterizer_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench: font loads and glyph draws against a row predictor.
module proportional_font_glyph_rasterizer_test;

  localparam int unsigned CYCLE_LIMIT   = 1_500_000;
  localparam int unsigned SETTLE_CYCLES = 400;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned HOLD_AFTER    = 60;
  localparam int unsigned CALM_FROM     = 2_000;
  localparam int unsigned CALM_TO       = 5_000;
  localparam int unsigned IDLE_PERCENT  = 12;
  localparam int unsigned PHASE_ITEMS   = 80;

  logic                         clk_i;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_ready_o;
  pfgr_pkg::in_req_t            in_req_i    = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  pfgr_pkg::out_rsp_t           out_rsp_o;
  logic                         cfg_we_i    = 1'b0;
  logic                         cfg_idx_i   = pfgr_pkg::REG_FOREGROUND;
  logic [pfgr_pkg::COLOR_W-1:0] cfg_data_i  = '0;

  proportional_font_glyph_rasterizer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  pfgr_pkg::in_req_t            pending_reqs [$];
  pfgr_pkg::out_rsp_t           expected_rows [$];
  int unsigned                  cycles     = 0;
  int unsigned                  mismatches = 0;
  int unsigned                  pushed_items = 0;

  logic [7:0]                   font_img [pfgr_pkg::FONT_BYTES];
  logic [pfgr_pkg::XY_W-1:0]    cursor_x = '0;
  logic [pfgr_pkg::XY_W-1:0]    cursor_y = '0;
  logic                         string_dropped = 1'b0;
  logic [pfgr_pkg::COLOR_W-1:0] ink_color = pfgr_pkg::FOREGROUND_RESET;
  logic [pfgr_pkg::COLOR_W-1:0] paper_color = pfgr_pkg::BACKGROUND_RESET;

  logic [7:0]                   plan_img [pfgr_pkg::FONT_BYTES];
  bit                           plan_written [pfgr_pkg::FONT_BYTES];

  int unsigned                  sink_count = 0;
  int unsigned                  hold_left  = 0;
  bit                           hold_done  = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int unsigned row_span(int unsigned w);
    return (w == 0) ? 1 : (w + 7) / 8;
  endfunction

  function automatic bit take_break();
    return !(cycles >= CALM_FROM && cycles < CALM_TO) && $urandom_range(99) < IDLE_PERCENT;
  endfunction

  function automatic void predict_glyph_rows(pfgr_pkg::in_req_t req);
    int unsigned height, first, count, idx, w, bpr, start, rows, base, b;
    logic [pfgr_pkg::PIX_W-1:0] px;
    pfgr_pkg::out_rsp_t row;
    logic fits;
    if (req.new_string) begin
      cursor_x = req.start_x;
      cursor_y = req.start_y;
      string_dropped = 1'b0;
    end
    if (string_dropped) return;
    height = 32'(font_img[pfgr_pkg::HEIGHT_ADDR]);
    first = 32'(font_img[pfgr_pkg::FIRST_ADDR]);
    count = 32'(font_img[pfgr_pkg::COUNT_ADDR]);
    fits = 32'(req.char_code) >= first && 32'(req.char_code) < first + count;
    idx = 32'(req.char_code) - first;
    w = fits ? 32'(font_img[(32'(pfgr_pkg::WIDTH_BASE) + idx) % pfgr_pkg::FONT_BYTES]) : 0;
    row = '0;
    row.pixel_x = cursor_x;
    row.pixel_y = cursor_y;
    row.set_color = ink_color;
    row.clear_color = paper_color;
    if (!fits || w > pfgr_pkg::MAX_GLYPH_WIDTH) begin
      string_dropped = 1'b1;
      row.last_row = 1'b1;
      row.error = 1'b1;
      expected_rows.push_back(row);
      return;
    end
    start = (32'(pfgr_pkg::WIDTH_BASE) + count) % pfgr_pkg::FONT_BYTES;
    for (int unsigned i = 0; i < idx; i++) begin
      start = (start + height * row_span(32'(font_img[(32'(pfgr_pkg::WIDTH_BASE) + i)
                                                        % pfgr_pkg::FONT_BYTES])))
              % pfgr_pkg::FONT_BYTES;
    end
    bpr = row_span(w);
    rows = (height > pfgr_pkg::MAX_GLYPH_HEIGHT) ? pfgr_pkg::MAX_GLYPH_HEIGHT : height;
    for (int unsigned r = 0; r < rows; r++) begin
      base = (start + r * bpr) % pfgr_pkg::FONT_BYTES;
      px = '0;
      for (int unsigned c = 0; c < w; c++) begin
        b = w - 1 - c;
        px[c] = font_img[(base + b / 8) % pfgr_pkg::FONT_BYTES][b % 8];
      end
      row.row_pixels = px;
      row.row_width = pfgr_pkg::RW_W'(w);
      row.pixel_y = pfgr_pkg::XY_W'(32'(cursor_y) + r);
      row.last_row = (r + 1 == rows);
      expected_rows.push_back(row);
    end
    cursor_x = pfgr_pkg::XY_W'(32'(cursor_x) + w);
  endfunction

  function automatic pfgr_pkg::in_req_t random_req();
    logic [$bits(pfgr_pkg::in_req_t)-1:0] raw;
    raw = $bits(pfgr_pkg::in_req_t)'({$urandom, $urandom});
    return pfgr_pkg::in_req_t'(raw);
  endfunction

  function automatic void queue_load(int unsigned addr, logic [7:0] data, logic force_new);
    pfgr_pkg::in_req_t req;
    req = random_req();
    req.action = pfgr_pkg::ACT_LOAD;
    req.font_addr = pfgr_pkg::ADDR_W'(addr);
    req.font_byte = data;
    if (force_new) req.new_string = 1'b1;
    plan_img[addr % pfgr_pkg::FONT_BYTES] = data;
    plan_written[addr % pfgr_pkg::FONT_BYTES] = 1'b1;
    pending_reqs.push_back(req);
    pushed_items++;
  endfunction

  function automatic void fill_byte(int unsigned addr);
    if (!plan_written[addr % pfgr_pkg::FONT_BYTES]) begin
      queue_load(addr % pfgr_pkg::FONT_BYTES, 8'($urandom), 1'b0);
    end
  endfunction

  // Every byte that a draw's result depends on is loaded first, so no result depends on an unwritten byte.
  function automatic void queue_draw(logic [7:0] code, logic start_new, int unsigned x,
                                     int unsigned y);
    int unsigned height, first, count, idx, w, bpr, start, rows;
    pfgr_pkg::in_req_t req;
    fill_byte(32'(pfgr_pkg::HEIGHT_ADDR));
    fill_byte(32'(pfgr_pkg::FIRST_ADDR));
    fill_byte(32'(pfgr_pkg::COUNT_ADDR));
    height = 32'(plan_img[pfgr_pkg::HEIGHT_ADDR]);
    first = 32'(plan_img[pfgr_pkg::FIRST_ADDR]);
    count = 32'(plan_img[pfgr_pkg::COUNT_ADDR]);
    if (32'(code) >= first && 32'(code) < first + count) begin
      idx = 32'(code) - first;
      fill_byte(32'(pfgr_pkg::WIDTH_BASE) + idx);
      w = 32'(plan_img[(32'(pfgr_pkg::WIDTH_BASE) + idx) % pfgr_pkg::FONT_BYTES]);
      if (w <= pfgr_pkg::MAX_GLYPH_WIDTH) begin
        start = (32'(pfgr_pkg::WIDTH_BASE) + count) % pfgr_pkg::FONT_BYTES;
        for (int unsigned i = 0; i < idx; i++) begin
          fill_byte(32'(pfgr_pkg::WIDTH_BASE) + i);
          start = (start + height * row_span(32'(plan_img[(32'(pfgr_pkg::WIDTH_BASE) + i)
                                                            % pfgr_pkg::FONT_BYTES])))
                  % pfgr_pkg::FONT_BYTES;
        end
        bpr = row_span(w);
        rows = (height > pfgr_pkg::MAX_GLYPH_HEIGHT) ? pfgr_pkg::MAX_GLYPH_HEIGHT : height;
        if (w != 0) begin
          for (int unsigned r = 0; r < rows; r++) begin
            for (int unsigned k = 0; k < bpr; k++) fill_byte(start + r * bpr + k);
          end
        end
      end
    end
    req = random_req();
    req.action = pfgr_pkg::ACT_DRAW;
    req.char_code = code;
    req.new_string = start_new;
    if (start_new) begin
      req.start_x = pfgr_pkg::XY_W'(x);
      req.start_y = pfgr_pkg::XY_W'(y);
    end
    pending_reqs.push_back(req);
    pushed_items++;
  endfunction

  function automatic void queue_font(int unsigned height, int unsigned first,
                                     input logic [7:0] widths [$]);
    queue_load(32'(pfgr_pkg::HEIGHT_ADDR), 8'(height), 1'b0);
    queue_load(32'(pfgr_pkg::FIRST_ADDR), 8'(first), 1'b0);
    queue_load(32'(pfgr_pkg::COUNT_ADDR), 8'(widths.size()), 1'b0);
    foreach (widths[i]) queue_load(32'(pfgr_pkg::WIDTH_BASE) + 32'(i), widths[i], 1'b0);
  endfunction

  function automatic logic [7:0] pick_width();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 6) return 8'($urandom_range(255, 65));
    if (roll < 14) return 8'(pfgr_pkg::MAX_GLYPH_WIDTH);
    return 8'($urandom_range(24));
  endfunction

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || expected_rows.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_colors(logic [pfgr_pkg::COLOR_W-1:0] fg,
                            logic [pfgr_pkg::COLOR_W-1:0] bg);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= pfgr_pkg::REG_FOREGROUND;
    cfg_data_i <= fg;
    @(posedge clk_i);
    cfg_idx_i <= pfgr_pkg::REG_BACKGROUND;
    cfg_data_i <= bg;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ink_color = fg;
    paper_color = bg;
  endtask

  always @(posedge clk_i) begin : drive_requests
    logic taken;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      taken = in_valid_i && in_ready_o;
      if (taken) begin
        if (in_req_i.action == pfgr_pkg::ACT_LOAD) begin
          font_img[in_req_i.font_addr] = in_req_i.font_byte;
        end else begin
          predict_glyph_rows(in_req_i);
        end
      end
      if (taken || !in_valid_i) begin
        if (pending_reqs.size() != 0 && !take_break()) begin
          in_req_i <= pending_reqs.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) sink_count++;
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!hold_done && sink_count >= HOLD_AFTER && out_valid_o) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !take_break();
      end
    end
  end

  function automatic void report_row(string why, pfgr_pkg::out_rsp_t want,
                                     pfgr_pkg::out_rsp_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s", $time, why);
      $display("  expected px=%h w=%0d x=%0d y=%0d fg=%h bg=%h last=%b err=%b",
               want.row_pixels, want.row_width, want.pixel_x, want.pixel_y,
               want.set_color, want.clear_color, want.last_row, want.error);
      $display("  actual   px=%h w=%0d x=%0d y=%0d fg=%h bg=%h last=%b err=%b",
               got.row_pixels, got.row_width, got.pixel_x, got.pixel_y,
               got.set_color, got.clear_color, got.last_row, got.error);
    end
  endfunction

  always @(posedge clk_i) begin : check_rows
    pfgr_pkg::out_rsp_t want;
    logic bad;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_rows.size() == 0) begin
        report_row("glyph row with no request pending", '0, out_rsp_o);
      end else begin
        want = expected_rows.pop_front();
        bad = out_rsp_o.row_pixels !== want.row_pixels
           || out_rsp_o.row_width !== want.row_width
           || out_rsp_o.pixel_x !== want.pixel_x
           || out_rsp_o.pixel_y !== want.pixel_y
           || out_rsp_o.set_color !== want.set_color
           || out_rsp_o.clear_color !== want.clear_color
           || out_rsp_o.last_row !== want.last_row
           || out_rsp_o.error !== want.error;
        if (bad) report_row("glyph row mismatch", want, out_rsp_o);
      end
    end
  end

  initial begin : stimulus
    logic [7:0] widths [$];
    logic [7:0] code;
    logic start_new;
    int unsigned height, first, count, phase_end, string_left, roll;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    widths = '{8'd0, 8'd1, 8'd8, 8'd9, 8'd64, 8'd65, 8'd255};
    queue_font(2, 32'h2C, widths);
    queue_draw(8'h2C, 1'b1, 0, 0);
    queue_draw(8'h2D, 1'b0, 0, 0);
    queue_draw(8'h2E, 1'b0, 0, 0);
    queue_draw(8'h2F, 1'b0, 0, 0);
    queue_draw(8'h30, 1'b0, 0, 0);
    queue_draw(8'h31, 1'b0, 0, 0);
    queue_draw(8'h2C, 1'b0, 0, 0);
    queue_draw(8'h2B, 1'b1, 300, 40);
    queue_draw(8'h33, 1'b1, 301, 41);
    queue_draw(8'h00, 1'b1, 0, 2047);
    queue_draw(8'hFF, 1'b1, 2047, 2047);
    queue_draw(8'h32, 1'b1, 7, 9);
    queue_draw(8'h30, 1'b1, 2040, 2047);
    queue_draw(8'h2F, 1'b0, 0, 0);
    queue_load(0, 8'hA5, 1'b1);
    queue_draw(8'h2D, 1'b0, 0, 0);
    wait_drained();

    set_colors(16'h0000, 16'hFFFF);
    widths = '{8'd5};
    queue_font(0, 32'hFF, widths);
    queue_draw(8'hFF, 1'b1, 10, 20);
    queue_load(32'(pfgr_pkg::HEIGHT_ADDR), 8'd1, 1'b0);
    queue_draw(8'hFF, 1'b0, 0, 0);
    queue_draw(8'hFE, 1'b0, 0, 0);
    widths = '{8'd255, 8'd1, 8'd64};
    queue_font(255, 0, widths);
    queue_draw(8'h01, 1'b1, 100, 2000);
    queue_draw(8'h00, 1'b1, 5, 5);
    queue_draw(8'h01, 1'b0, 0, 0);
    queue_draw(8'h03, 1'b1, 6, 6);

    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      unique case (phase)
        0: set_colors(pfgr_pkg::COLOR_W'($urandom), pfgr_pkg::COLOR_W'($urandom));
        1: set_colors(16'hFFFF, 16'hFFFF);
        2: set_colors(pfgr_pkg::COLOR_W'($urandom), pfgr_pkg::COLOR_W'($urandom));
        default: set_colors(16'h0000, 16'h0000);
      endcase
      roll = $urandom_range(99);
      height = (roll < 10) ? 0 : (roll < 85) ? $urandom_range(8, 1) : $urandom_range(24, 9);
      first = $urandom_range(255);
      count = ($urandom_range(99) < 5) ? 0 : $urandom_range(16, 1);
      widths.delete();
      repeat (count) widths.push_back(pick_width());
      queue_font(height, first, widths);
      phase_end = pushed_items + PHASE_ITEMS;
      string_left = 0;
      while (pushed_items < phase_end) begin
        if ($urandom_range(99) < 8) begin
          queue_load($urandom_range(pfgr_pkg::FONT_BYTES - 1,
                                    32'(pfgr_pkg::WIDTH_BASE) + count),
                     8'($urandom), 1'b0);
        end else begin
          start_new = (string_left == 0) || ($urandom_range(99) < 5);
          if (start_new) string_left = $urandom_range(8, 1);
          string_left--;
          roll = $urandom_range(99);
          if (count != 0 && roll < 88) code = 8'(first + $urandom_range(count - 1));
          else if (roll < 94) code = roll[0] ? 8'(first - 1) : 8'(first + count);
          else code = 8'($urandom);
          queue_draw(code, start_new, $urandom_range(2047), $urandom_range(2047));
        end
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
